[rtl/core/smf_pkg.sv]
// Package for the sliding window median filter: sizes, register indexes and
// the structs passed between the filter's modules. No dependencies.
`default_nettype none
package smf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_KERNEL  = 11;
  localparam int KMAX        = (MAX_KERNEL - 1) | 1;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROWM_W      = $clog2(MAX_KERNEL);
  localparam int ADDR_W      = ROWM_W + COL_W;
  localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int K_W         = 4;
  localparam int R_W         = $clog2(MAX_KERNEL / 2 + 1);
  localparam int N_W         = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int WID_W       = 11;
  localparam int HGT_W       = 16;
  localparam int LAT_W       = $clog2((MAX_KERNEL / 2) * MAX_WIDTH + MAX_KERNEL / 2 + 2);
  localparam int PIX_W       = 8;
  localparam int BIT_W       = $clog2(PIX_W);
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  typedef enum logic [1:0] {
    REG_KERNEL = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  // Effective (clamped) frame geometry.
  typedef struct packed {
    logic [K_W-1:0]   k;
    logic [R_W-1:0]   r;
    logic [N_W-1:0]   n;
    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;
  } cfg_t;

  // Commands from the sequencer to the rank selection unit.
  typedef struct packed {
    logic             start;
    logic             decide;
    logic [BIT_W-1:0] bit_idx;
  } rank_ctl_t;

endpackage
`default_nettype wire

[rtl/core/smf_if.sv]
// Stream interfaces for the median filter's input and result channels.
// Depends on smf_pkg for the pixel width.
`default_nettype none
interface smf_in_if import smf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_value;
  modport source (output valid, mode, pixel_value, input ready);
  modport sink   (input valid, mode, pixel_value, output ready);
endinterface

interface smf_out_if import smf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             frame_end;
  modport source (output valid, out_pixel, frame_end, input ready);
  modport sink   (input valid, out_pixel, frame_end, output ready);
endinterface
`default_nettype wire

[rtl/core/sliding_window_median_filter.sv]
// Sliding window median filter: a border pixel is copied from the line store, and
// an interior median is found by eight counting passes that share the line
// store's single read port. No new request is taken while one is in progress.
// Results leave through an output register. Reset clears all positions and
// loads kernel 3, width 640, height 480; line store is not cleared.
`default_nettype none
module sliding_window_median_filter import smf_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  smf_in_if.sink             pix_i,
  smf_out_if.source          res_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [PADDR_W-1:0] paddr,
  input  wire  [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_EDGE_RD, S_EDGE_WAIT, S_MED_RD, S_MED_WAIT, S_MED_DEC, S_OUT
  } state_e;

  state_e            state_q;
  cfg_t              cfg;
  logic              restart;
  rank_ctl_t         rank_ctl;
  logic [PIX_W-1:0]  prefix;
  logic [PIX_W-1:0]  rd_data;

  logic [COL_W-1:0]  in_col_q;
  logic [HGT_W-1:0]  in_row_q;
  logic [ROWM_W-1:0] in_rowm_q;
  logic              all_rcvd_q;
  logic [COL_W-1:0]  ox_q;
  logic [HGT_W-1:0]  oy_q;
  logic [ROWM_W-1:0] oy_mod_q;
  logic [LAT_W-1:0]  diff_q;

  logic [BIT_W-1:0]  bit_q;
  logic [K_W-1:0]    wi_q;
  logic [K_W-1:0]    wj_q;
  logic [ROWM_W-1:0] wrow_q;
  logic              rd_vld_q;
  logic              is_med_q;
  logic [PIX_W-1:0]  res_q;
  logic              out_vld_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_end_q;

  logic              accept;
  logic              store_wr;
  logic [LAT_W-1:0]  latency;
  logic              due;
  logic              interior;
  logic [ROWM_W-1:0] top_rowm;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [COL_W:0]    wcol;
  logic              last_out;
  logic              out_free;

  smf_apb u_apb (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  smf_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i,
    .we_i    (store_wr),
    .waddr_i ({in_rowm_q, in_col_q}),
    .wdata_i (pix_i.pixel_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  smf_rank u_rank (
    .clk_i, .rst_ni,
    .ctl_i      (rank_ctl),
    .n_i        (cfg.n),
    .data_vld_i (rd_vld_q),
    .data_i     (rd_data),
    .prefix_o   (prefix)
  );

  assign pix_i.ready   = (state_q == S_IDLE);
  assign accept        = pix_i.valid && pix_i.ready;
  assign store_wr      = accept && !pix_i.mode && !all_rcvd_q;
  assign res_o.valid     = out_vld_q;
  assign res_o.out_pixel = out_pix_q;
  assign res_o.frame_end = out_end_q;
  assign out_free      = !out_vld_q || res_o.ready;

  always_comb begin
    latency  = LAT_W'(LAT_W'(cfg.r) * LAT_W'(cfg.w)) + LAT_W'(cfg.r);
    due      = (diff_q > latency) || all_rcvd_q;
    interior = (oy_q >= HGT_W'(cfg.r))
            && ((HGT_W+1)'(oy_q) + (HGT_W+1)'(cfg.r) < (HGT_W+1)'(cfg.h))
            && (ox_q >= COL_W'(cfg.r))
            && ((COL_W+1)'(ox_q) + (COL_W+1)'(cfg.r) < (COL_W+1)'(cfg.w));
    top_rowm = (oy_mod_q >= ROWM_W'(cfg.r)) ? oy_mod_q - ROWM_W'(cfg.r)
             : oy_mod_q + ROWM_W'(MAX_KERNEL) - ROWM_W'(cfg.r);
    wcol     = (COL_W+1)'(ox_q) - (COL_W+1)'(cfg.r) + (COL_W+1)'(wj_q);
    last_out = (oy_q == cfg.h - HGT_W'(1)) && ((WID_W)'(ox_q) == cfg.w - WID_W'(1));
    ram_re    = (state_q == S_EDGE_RD) || (state_q == S_MED_RD);
    ram_raddr = (state_q == S_MED_RD) ? {wrow_q, wcol[COL_W-1:0]} : {oy_mod_q, ox_q};
  end

  always_comb begin
    rank_ctl.start   = (state_q == S_CHECK);
    rank_ctl.decide  = (state_q == S_MED_DEC);
    rank_ctl.bit_idx = bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_rowm_q  <= '0;
      all_rcvd_q <= 1'b0;
      ox_q       <= '0;
      oy_q       <= '0;
      oy_mod_q   <= '0;
      diff_q     <= '0;
      bit_q      <= '0;
      wi_q       <= '0;
      wj_q       <= '0;
      wrow_q     <= '0;
      rd_vld_q   <= 1'b0;
      is_med_q   <= 1'b0;
      res_q      <= '0;
      out_vld_q  <= 1'b0;
      out_pix_q  <= '0;
      out_end_q  <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_MED_RD);
      // In the output state, unless a restart comes, the register is reloaded below whenever it drains.
      if (out_vld_q && res_o.ready && (state_q != S_OUT || restart)) begin
        out_vld_q <= 1'b0;
      end
      if (restart) begin
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_rowm_q  <= '0;
        all_rcvd_q <= 1'b0;
        ox_q       <= '0;
        oy_q       <= '0;
        oy_mod_q   <= '0;
        diff_q     <= '0;
      end else begin
        case (state_q)
          S_IDLE: begin
            if (accept) begin
              if (store_wr) begin
                diff_q <= diff_q + LAT_W'(1);
                if (WID_W'(in_col_q) == cfg.w - WID_W'(1)) begin
                  in_col_q  <= '0;
                  in_row_q  <= in_row_q + HGT_W'(1);
                  in_rowm_q <= (in_rowm_q == ROWM_W'(MAX_KERNEL - 1)) ? '0
                             : in_rowm_q + ROWM_W'(1);
                  if (in_row_q == cfg.h - HGT_W'(1)) begin
                    all_rcvd_q <= 1'b1;
                  end
                end else begin
                  in_col_q <= in_col_q + COL_W'(1);
                end
              end
              state_q <= S_CHECK;
            end
          end
          S_CHECK: begin
            bit_q  <= BIT_W'(PIX_W - 1);
            wi_q   <= '0;
            wj_q   <= '0;
            wrow_q <= top_rowm;
            if (!due) begin
              state_q <= S_IDLE;
            end else if (interior) begin
              is_med_q <= 1'b1;
              state_q  <= S_MED_RD;
            end else begin
              is_med_q <= 1'b0;
              state_q  <= S_EDGE_RD;
            end
          end
          S_EDGE_RD: state_q <= S_EDGE_WAIT;
          S_EDGE_WAIT: begin
            res_q   <= rd_data;
            state_q <= S_OUT;
          end
          S_MED_RD: begin
            if (wj_q == cfg.k - K_W'(1)) begin
              wj_q   <= '0;
              wi_q   <= wi_q + K_W'(1);
              wrow_q <= (wrow_q == ROWM_W'(MAX_KERNEL - 1)) ? '0 : wrow_q + ROWM_W'(1);
              if (wi_q == cfg.k - K_W'(1)) begin
                state_q <= S_MED_WAIT;
              end
            end else begin
              wj_q <= wj_q + K_W'(1);
            end
          end
          S_MED_WAIT: state_q <= S_MED_DEC;
          S_MED_DEC: begin
            wi_q   <= '0;
            wj_q   <= '0;
            wrow_q <= top_rowm;
            if (bit_q == '0) begin
              state_q <= S_OUT;
            end else begin
              bit_q   <= bit_q - BIT_W'(1);
              state_q <= S_MED_RD;
            end
          end
          S_OUT: begin
            if (out_free) begin
              out_vld_q <= 1'b1;
              out_pix_q <= is_med_q ? prefix : res_q;
              out_end_q <= last_out;
              state_q   <= S_IDLE;
              if (last_out) begin
                in_col_q   <= '0;
                in_row_q   <= '0;
                in_rowm_q  <= '0;
                all_rcvd_q <= 1'b0;
                ox_q       <= '0;
                oy_q       <= '0;
                oy_mod_q   <= '0;
                diff_q     <= '0;
              end else begin
                diff_q <= diff_q - LAT_W'(1);
                if (WID_W'(ox_q) == cfg.w - WID_W'(1)) begin
                  ox_q     <= '0;
                  oy_q     <= oy_q + HGT_W'(1);
                  oy_mod_q <= (oy_mod_q == ROWM_W'(MAX_KERNEL - 1)) ? '0
                            : oy_mod_q + ROWM_W'(1);
                end else begin
                  ox_q <= ox_q + COL_W'(1);
                end
              end
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  a_diff_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    diff_q <= latency + LAT_W'(1))
    else $error("pending pixel count exceeds the window latency");

  a_out_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (diff_q != '0))
    else $error("result produced with no pixel pending");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free && last_out && !restart) |=>
      (ox_q == '0 && oy_q == '0 && diff_q == '0 && !all_rcvd_q))
    else $error("positions not cleared after the last pixel of the frame");

endmodule
`default_nettype wire

[rtl/core/smf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module smf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/core/smf_apb.sv]
// Configuration registers behind the APB-style port, with clamping of the
// raw values to the effective geometry. Depends on smf_pkg.
`default_nettype none
module smf_apb import smf_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [PADDR_W-1:0] paddr,
  input  wire  [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o,
  output logic               restart_o
);

  logic [K_W-1:0]   kernel_q;
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic             wr;
  reg_idx_e         idx;
  logic [K_W-1:0]   k_odd;
  logic [K_W-1:0]   k_eff;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= K_W'(3);
      width_q  <= WID_W'(640);
      height_q <= HGT_W'(480);
    end else if (wr) begin
      case (idx)
        REG_KERNEL: kernel_q <= pwdata[K_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[WID_W-1:0];
        REG_HEIGHT: height_q <= pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart_o = 1'b0;
    prdata    = '0;
    case (idx)
      REG_KERNEL: begin
        restart_o = wr;
        prdata    = PDATA_W'(kernel_q);
      end
      REG_WIDTH: begin
        restart_o = wr;
        prdata    = PDATA_W'(width_q);
      end
      REG_HEIGHT: begin
        restart_o = wr;
        prdata    = PDATA_W'(height_q);
      end
      default: ;
    endcase
  end

  // Even sizes round up to the next odd one, then clamp to the legal range.
  always_comb begin
    k_odd = kernel_q[0] ? kernel_q : kernel_q + K_W'(1);
    k_eff = k_odd;
    if (k_odd < K_W'(3)) begin
      k_eff = K_W'(3);
    end else if (k_odd > K_W'(KMAX)) begin
      k_eff = K_W'(KMAX);
    end
  end

  always_comb begin
    cfg_o.k = k_eff;
    cfg_o.r = R_W'(k_eff >> 1);
    cfg_o.n = N_W'(N_W'(k_eff) * N_W'(k_eff));
    if (width_q == '0) begin
      cfg_o.w = WID_W'(1);
    end else if (width_q > WID_W'(MAX_WIDTH)) begin
      cfg_o.w = WID_W'(MAX_WIDTH);
    end else begin
      cfg_o.w = width_q;
    end
    cfg_o.h = (height_q == '0) ? HGT_W'(1) : height_q;
  end

endmodule
`default_nettype wire

[rtl/core/smf_rank.sv]
// Bitwise radix selection unit: one counting pass per result bit, finding the
// value of a given rank among the streamed window values. Depends on smf_pkg.
`default_nettype none
module smf_rank import smf_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  rank_ctl_t        ctl_i,
  input  wire  [N_W-1:0]   n_i,
  input  wire              data_vld_i,
  input  wire  [PIX_W-1:0] data_i,
  output logic [PIX_W-1:0] prefix_o
);

  logic [N_W-1:0]   cnt_q;
  logic [N_W-1:0]   rank_q;
  logic [PIX_W-1:0] prefix_q;
  logic [PIX_W-1:0] hi_mask;
  logic             match;

  // A value counts when it agrees with the settled upper bits and has a zero
  // in the bit under decision.
  always_comb begin
    hi_mask = (PIX_W'({PIX_W{1'b1}}) << ctl_i.bit_idx) << 1;
    match   = (((data_i ^ prefix_q) & hi_mask) == '0) && !data_i[ctl_i.bit_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rank_q   <= '0;
      prefix_q <= '0;
    end else if (ctl_i.start) begin
      cnt_q    <= '0;
      rank_q   <= n_i >> 1;
      prefix_q <= '0;
    end else if (ctl_i.decide) begin
      cnt_q <= '0;
      if (rank_q >= cnt_q) begin
        prefix_q[ctl_i.bit_idx] <= 1'b1;
        rank_q                  <= rank_q - cnt_q;
      end
    end else if (data_vld_i && match) begin
      cnt_q <= cnt_q + N_W'(1);
    end
  end

  assign prefix_o = prefix_q;

endmodule
`default_nettype wire

[dv/sliding_window_median_filter_tb.sv]
// Self-checking testbench for the sliding window median filter: a directed
// table, then random frames, checked against a median predictor in this file.
// Depends on smf_pkg, the smf_in_if/smf_out_if interfaces and the filter RTL.
`default_nettype none
module sliding_window_median_filter_tb;
  import smf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} row_kind_e;
  typedef enum logic [1:0] {OUT_PREDICT, OUT_NONE, OUT_TYPED} row_out_e;

  typedef struct {
    row_kind_e  kind;
    reg_idx_e   idx;
    int         value;
    logic       mode;
    logic [7:0] pix;
    row_out_e   chk;
    logic [7:0] exp_pix;
    logic       exp_fe;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       fe;
  } filt_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  smf_in_if  pix_if ();
  smf_out_if res_if ();

  sliding_window_median_filter dut (
    .clk_i, .rst_ni, .pix_i(pix_if.sink), .res_o(res_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [7:0]  row_buf [MAX_KERNEL*MAX_WIDTH];
  int unsigned col_pos, row_pos, emit_pos;
  logic [3:0]  kern_reg;
  logic [10:0] wid_reg;
  logic [15:0] hgt_reg;

  filt_res_t   pending_res [$];
  int          errors = 0;
  int          items_sent = 0;
  bit          quiet = 1'b0;

  initial begin
    pix_if.valid = 1'b0;
    pix_if.mode = 1'b0;
    pix_if.pixel_value = '0;
    res_if.ready = 1'b0;
    foreach (row_buf[i]) row_buf[i] = '0;
  end

  function automatic int unsigned buf_addr(int unsigned y, int unsigned x);
    return (y % MAX_KERNEL) * MAX_WIDTH + (x % MAX_WIDTH);
  endfunction

  function automatic int unsigned kern_eff();
    int unsigned k;
    k = kern_reg;
    if (k[0] == 1'b0) k++;
    if (k < 3) k = 3;
    if (k > KMAX) k = KMAX;
    return k;
  endfunction

  function automatic int unsigned wid_eff();
    int unsigned w;
    w = wid_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned hgt_eff();
    return (hgt_reg == 0) ? 1 : hgt_reg;
  endfunction

  function automatic void restart_positions();
    col_pos = 0;
    row_pos = 0;
    emit_pos = 0;
  endfunction

  function automatic void cfg_model(reg_idx_e idx, int value);
    case (idx)
      REG_KERNEL: kern_reg = value[3:0];
      REG_WIDTH:  wid_reg = value[10:0];
      REG_HEIGHT: hgt_reg = value[15:0];
      default: ;
    endcase
    restart_positions();
  endfunction

  function automatic void expect_res(filt_res_t res);
    pending_res.insert(pending_res.size(), res);
  endfunction

  function automatic logic [7:0] window_median(int unsigned y, int unsigned x, int unsigned k);
    logic [7:0] vals [$];
    int unsigned r;
    r = k / 2;
    for (int unsigned i = 0; i < k; i++)
      for (int unsigned j = 0; j < k; j++)
        vals.insert(vals.size(), row_buf[buf_addr(y - r + i, x - r + j)]);
    vals.sort();
    return vals[vals.size() / 2];
  endfunction

  // Advances the filter model by one request; returns 1 when a pixel leaves.
  function automatic bit filter_step(logic mode, logic [7:0] pix, output filt_res_t res);
    int unsigned k, r, w, h, total, lat, got, y, x;
    k = kern_eff();
    r = k / 2;
    w = wid_eff();
    h = hgt_eff();
    total = w * h;
    lat = r * w + r;
    got = row_pos * w + col_pos;
    res = '0;
    if (!mode && got < total) begin
      row_buf[buf_addr(row_pos, col_pos)] = pix;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      got++;
    end
    if (emit_pos >= total) return 1'b0;
    if (!(got > emit_pos + lat || got == total)) return 1'b0;
    y = emit_pos / w;
    x = emit_pos % w;
    if (y >= r && y + r < h && x >= r && x + r < w) res.pix = window_median(y, x, k);
    else res.pix = row_buf[buf_addr(y, x)];
    res.fe = (emit_pos == total - 1);
    emit_pos++;
    if (emit_pos >= total) restart_positions();
    return 1'b1;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    filt_res_t want;
    if (res_if.valid && res_if.ready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result: out_pixel %0d frame_end %0b",
               res_if.out_pixel, res_if.frame_end);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (res_if.out_pixel !== want.pix) begin
          $error("out_pixel: expected %0d, got %0d", want.pix, res_if.out_pixel);
          errors++;
        end
        if (res_if.frame_end !== want.fe) begin
          $error("frame_end: expected %0b, got %0b", want.fe, res_if.frame_end);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 25)) @(posedge clk_i);
    end
  end

  task automatic send_request(logic mode, logic [7:0] pix, row_out_e chk = OUT_PREDICT,
                              filt_res_t typed = '0);
    filt_res_t res;
    bit        has;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.mode <= mode;
    pix_if.pixel_value <= pix;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    items_sent++;
    has = filter_step(mode, pix, res);
    if (chk == OUT_TYPED) expect_res(typed);
    else if (has) expect_res(res);
    if (chk == OUT_NONE && has) begin
      $error("directed row: predictor gives a result where none is due");
      errors++;
    end
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, int value);
    logic [PDATA_W-1:0] mask;
    mask = (idx == REG_KERNEL) ? 32'hF : (idx == REG_WIDTH) ? 32'h7FF : 32'hFFFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    cfg_model(idx, value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (value & mask)) begin
      $error("prdata: expected %0h, got %0h", value & mask, prdata & mask);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // One frame at the given geometry; an aborted frame, or one of over 400 pixels, is
  // cut short by the next register write, which drops whatever input is still pending.
  task automatic run_frame(int k, int w, int h, bit abort);
    int unsigned total, n;
    filt_res_t   dummy;
    wait_idle();
    reg_write(REG_KERNEL, k);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    total = wid_eff() * hgt_eff();
    n = total;
    if (abort || total > 400) n = $urandom_range(1, (total > 40) ? 40 : total);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send_request(1'b1, 8'($urandom));
      send_request(1'b0, 8'($urandom));
      if (items_sent > 1250) quiet = 1'b1;
    end
    if (n == total)
      while (!(emit_pos == 0 && row_pos == 0 && col_pos == 0))
        send_request(($urandom_range(0, 3) != 0), 8'($urandom));
  endtask

  stim_row_t table_rows [$];

  function automatic void add_row(stim_row_t s);
    table_rows.insert(table_rows.size(), s);
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_e idx, int value);
    stim_row_t s;
    s = '{ROW_CFG, idx, value, 1'b0, 8'd0, OUT_PREDICT, 8'd0, 1'b0};
    return s;
  endfunction

  function automatic stim_row_t item_row(logic mode, logic [7:0] pix, row_out_e chk,
                                         logic [7:0] ep = 0, logic ef = 0);
    stim_row_t s;
    s = '{ROW_ITEM, REG_KERNEL, 0, mode, pix, chk, ep, ef};
    return s;
  endfunction

  initial begin
    filt_res_t typed;
    int k, w, h;
    int grid_pix [8];
    kern_reg = 4'd3;
    wid_reg = 11'd640;
    hgt_reg = 16'd480;
    restart_positions();
    grid_pix = '{200, 30, 40, 255, 0, 70, 80, 90};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the default frame is far too large to produce anything.
    add_row(item_row(1'b0, 8'h00, OUT_NONE));
    add_row(item_row(1'b1, 8'hFF, OUT_NONE));
    // A one pixel frame passes straight through and ends at once.
    add_row(cfg_row(REG_WIDTH, 1));
    add_row(cfg_row(REG_HEIGHT, 1));
    add_row(item_row(1'b0, 8'hFF, OUT_TYPED, 8'hFF, 1'b1));
    add_row(item_row(1'b0, 8'h00, OUT_TYPED, 8'h00, 1'b1));
    add_row(item_row(1'b1, 8'h5A, OUT_NONE));
    // Three by three frame with a kernel register that reads as zero.
    add_row(cfg_row(REG_KERNEL, 0));
    add_row(cfg_row(REG_WIDTH, 3));
    add_row(cfg_row(REG_HEIGHT, 3));
    add_row(item_row(1'b0, 8'd10, OUT_PREDICT));
    add_row(item_row(1'b1, 8'd0, OUT_NONE));
    foreach (grid_pix[i])
      add_row(item_row(1'b0, 8'(grid_pix[i]), OUT_PREDICT));
    // Tail drain: three flushes and one pixel that acts as a flush.
    add_row(item_row(1'b1, 8'd0, OUT_PREDICT));
    add_row(item_row(1'b0, 8'd77, OUT_PREDICT));
    add_row(item_row(1'b1, 8'd0, OUT_PREDICT));
    add_row(item_row(1'b1, 8'd0, OUT_TYPED, 8'd90, 1'b1));

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == ROW_CFG) begin
        wait_idle();
        reg_write(table_rows[i].idx, table_rows[i].value);
      end else begin
        typed = '{table_rows[i].exp_pix, table_rows[i].exp_fe};
        send_request(table_rows[i].mode, table_rows[i].pix, table_rows[i].chk, typed);
      end
    end

    // Register extremes and out-of-range values
    run_frame(15, 2047, 65535, 1'b1);
    run_frame(11, 1024, 0, 1'b1);
    run_frame(2, 0, 0, 1'b0);
    run_frame(11, 12, 12, 1'b0);
    run_frame(14, 13, 11, 1'b0);
    run_frame(1, 5, 1, 1'b0);
    run_frame(4, 1, 7, 1'b0);

    while (items_sent < 1450) begin
      case ($urandom_range(0, 9))
        0:       k = $urandom_range(0, 15);
        1:       k = $urandom_range(7, 11);
        2, 3:    k = 5;
        default: k = 3;
      endcase
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 10);
      if (k >= 9 && $urandom_range(0, 1)) begin
        w = $urandom_range(1, 8);
      end
      run_frame(k, w, h, ($urandom_range(0, 9) == 0));
    end

    pix_if.valid <= 1'b0;
    quiet = 1'b1;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/core/smf_pkg.sv
rtl/core/smf_if.sv
rtl/core/smf_ram.sv
rtl/core/smf_apb.sv
rtl/core/smf_rank.sv
rtl/core/sliding_window_median_filter.sv
dv/sliding_window_median_filter_tb.sv
